/* rtl/rgpm_pkg.sv */
`timescale 1ns / 1ps

package rgpm_pkg;

  localparam int DIM_W     = 13;
  localparam int CTR_W     = DIM_W - 1;
  localparam int CH_W      = 8;
  localparam int GAIN_W    = 8;
  localparam int M_W       = 2 * CTR_W + 1;
  localparam int REG_IDX_W = 1;
  localparam int COORD_BITS_DEFAULT = 12;

  localparam int GAIN_MAX   = 255;
  localparam int GAIN_SLOPE = 254;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // gain overrides decided before the divider
  typedef struct packed {
    logic zero;
    logic pass;
  } gain_flags_t;

  // floor(p / 255), exact for p up to 255 * 255
  function automatic logic [CH_W-1:0] div_by_max(input logic [2*CH_W-1:0] p);
    logic [2*CH_W:0] s;
    s = {1'b0, p} + {{(CH_W+1){1'b0}}, p[2*CH_W-1:CH_W]} + (2*CH_W+1)'(1);
    return s[2*CH_W-1:CH_W];
  endfunction

endpackage

/* rtl/radial_gradient_pixel_mask.sv */
`timescale 1ns / 1ps
// channel | signals                                          | role
// pix     | pix_valid, pix_stall, pos_x, pos_y, *_in           | pixel in, with position
// res     | res_valid, res_stall, red_out, green_out, blue_out | masked pixel out
// cfg     | wr_en, wr_index, wr_data                           | image size registers
//
// one pixel per clock sustained while res_stall does not hold the output
// the gain divide is an 8 stage restoring divider, one quotient bit per stage
// each stage holds its item under stall and fills bubbles ahead of a stalled output
// rst clears the valid bits and sets both image dimensions to 256
// the mask radius register settles after a size write, through the cx_sq and cy_sq registers

module radial_gradient_pixel_mask #(
  parameter int COORD_BITS = rgpm_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rgpm_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [rgpm_pkg::DIM_W-1:0]     wr_data,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  logic [COORD_BITS-1:0]          pos_x,
  input  logic [COORD_BITS-1:0]          pos_y,
  input  logic [rgpm_pkg::CH_W-1:0]      red_in,
  input  logic [rgpm_pkg::CH_W-1:0]      green_in,
  input  logic [rgpm_pkg::CH_W-1:0]      blue_in,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [rgpm_pkg::CH_W-1:0]      red_out,
  output logic [rgpm_pkg::CH_W-1:0]      green_out,
  output logic [rgpm_pkg::CH_W-1:0]      blue_out
);
  import rgpm_pkg::*;

  localparam int DW    = (COORD_BITS > CTR_W) ? COORD_BITS : CTR_W;
  localparam int SQ_W  = 2 * DW;
  localparam int D2_W  = SQ_W + 1;
  localparam int NW    = M_W + GAIN_W;
  localparam int EW    = ((D2_W > M_W) ? D2_W : M_W) + GAIN_W;
  localparam int DIV_N = GAIN_W;
  localparam int NS    = 4 + DIV_N + 2;

  // size registers and derived radius
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [CTR_W-1:0]  cx;
  logic [CTR_W-1:0]  cy;
  logic [2*CTR_W-1:0] cx_sq;
  logic [2*CTR_W-1:0] cy_sq;
  logic [M_W-1:0]    m_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IMAGE_WIDTH:  image_width  <= wr_data;
        REG_IMAGE_HEIGHT: image_height <= wr_data;
        default: ;
      endcase
    end
  end

  assign cx = image_width[DIM_W-1:1];
  assign cy = image_height[DIM_W-1:1];

  always_ff @(posedge clk) begin
    cx_sq <= cx * cx;
    cy_sq <= cy * cy;
    m_reg <= {1'b0, cx_sq} + {1'b0, cy_sq};
  end

  // flow control
  logic [NS:1] vld;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !vld[NS] || !res_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_stall = !en[1];
  assign res_valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= pix_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: distance from centre
  logic signed [DW:0] dx;
  logic signed [DW:0] dy;
  logic [DW-1:0]      adx1;
  logic [DW-1:0]      ady1;
  pixel_t             pix1;

  assign dx = $signed({{(DW+1-COORD_BITS){1'b0}}, pos_x})
            - $signed({{(DW+1-CTR_W){1'b0}}, cx});
  assign dy = $signed({{(DW+1-COORD_BITS){1'b0}}, pos_y})
            - $signed({{(DW+1-CTR_W){1'b0}}, cy});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      adx1 <= dx[DW] ? DW'(-dx) : dx[DW-1:0];
      ady1 <= dy[DW] ? DW'(-dy) : dy[DW-1:0];
      pix1 <= '{red: red_in, green: green_in, blue: blue_in};
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0] sqx2;
  logic [SQ_W-1:0] sqy2;
  pixel_t          pix2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sqx2 <= adx1 * adx1;
      sqy2 <= ady1 * ady1;
      pix2 <= pix1;
    end
  end

  // stage 3: squared distance
  logic [D2_W-1:0] d2_3;
  pixel_t          pix3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d2_3 <= {1'b0, sqx2} + {1'b0, sqy2};
      pix3 <= pix2;
    end
  end

  // stage 4: numerator and saturation
  logic [EW-1:0] num_a;
  logic [EW-1:0] num_b;
  logic [EW-1:0] num_d;

  assign num_a = EW'(m_reg) * EW'(GAIN_MAX);
  assign num_b = EW'(d2_3) * EW'(GAIN_SLOPE);
  assign num_d = num_a - num_b;

  logic [NW-1:0]     rem  [0:DIV_N];
  logic [GAIN_W-1:0] quo  [0:DIV_N];
  gain_flags_t       flg  [0:DIV_N];
  pixel_t            dpix [0:DIV_N];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rem[0]      <= num_d[NW-1:0];
      quo[0]      <= '0;
      flg[0].pass <= (m_reg == '0);
      flg[0].zero <= (num_b >= num_a);
      dpix[0]     <= pix3;
    end
  end

  // stages 5 to 12: restoring divide by m, msb first
  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    localparam int BIT = DIV_N - 1 - j;
    logic [NW-1:0] dvs;
    logic          take;

    assign dvs  = NW'(m_reg) << BIT;
    assign take = rem[j] >= dvs;

    always_ff @(posedge clk) begin
      if (en[5+j]) begin
        rem[j+1]  <= take ? rem[j] - dvs : rem[j];
        quo[j+1]  <= quo[j] | (take ? GAIN_W'(1) << BIT : '0);
        flg[j+1]  <= flg[j];
        dpix[j+1] <= dpix[j];
      end
    end
  end

  // stage 13: channel times gain
  logic [GAIN_W-1:0]    gain;
  logic [2*CH_W-1:0]    pr13;
  logic [2*CH_W-1:0]    pg13;
  logic [2*CH_W-1:0]    pb13;

  always_comb begin
    priority if (flg[DIV_N].pass) begin
      gain = GAIN_W'(GAIN_MAX);
    end else if (flg[DIV_N].zero) begin
      gain = '0;
    end else begin
      gain = quo[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      pr13 <= dpix[DIV_N].red   * gain;
      pg13 <= dpix[DIV_N].green * gain;
      pb13 <= dpix[DIV_N].blue  * gain;
    end
  end

  // stage 14: scale back by 255
  always_ff @(posedge clk) begin
    if (en[NS]) begin
      red_out   <= div_by_max(pr13);
      green_out <= div_by_max(pg13);
      blue_out  <= div_by_max(pb13);
    end
  end

endmodule

/* rtl/rgpm_check.sv */
`timescale 1ns / 1ps

module rgpm_check #(
  parameter int COORD_BITS = rgpm_pkg::COORD_BITS_DEFAULT
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           pix_valid,
  input logic                           pix_stall,
  input logic [COORD_BITS-1:0]          pos_x,
  input logic [COORD_BITS-1:0]          pos_y,
  input logic [rgpm_pkg::CH_W-1:0]      red_in,
  input logic [rgpm_pkg::CH_W-1:0]      green_in,
  input logic [rgpm_pkg::CH_W-1:0]      blue_in,
  input logic                           res_valid,
  input logic                           res_stall,
  input logic [rgpm_pkg::CH_W-1:0]      red_out,
  input logic [rgpm_pkg::CH_W-1:0]      green_out,
  input logic [rgpm_pkg::CH_W-1:0]      blue_out
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !pix_stall)
    else $error("pipeline not empty after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> res_valid && res_stall)
    else $error("input stalled while output free");

  // a free output frees the input in the same cycle
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || !res_stall) |-> !pix_stall)
    else $error("input stalled with output able to move");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("stalled result changed");

  // stalled pixel holds
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(red_in) && $stable(green_in) && $stable(blue_in))
    else $error("stalled pixel changed");

endmodule

bind radial_gradient_pixel_mask rgpm_check #(.COORD_BITS(COORD_BITS)) u_rgpm_check (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rgpm_pkg::*;

  localparam int COORD_W = COORD_BITS_DEFAULT;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_PER_SIZE = 190;
  localparam int NUM_SIZES = 9;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pixel_t             rgb;
  } located_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]     wr_data = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [COORD_W-1:0]   pos_x = '0;
  logic [COORD_W-1:0]   pos_y = '0;
  logic [CH_W-1:0]      red_in = '0;
  logic [CH_W-1:0]      green_in = '0;
  logic [CH_W-1:0]      blue_in = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [CH_W-1:0]      red_out;
  logic [CH_W-1:0]      green_out;
  logic [CH_W-1:0]      blue_out;

  located_pixel_t pending_pixels[$];
  pixel_t         masked_due[$];
  located_pixel_t taken_pixel;
  pixel_t         due_pixel;

  int img_w = 256;
  int img_h = 256;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_in = 0;
  int pixels_out = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int sizes_run = 0;
  bit pix_taken = 1'b0;

  radial_gradient_pixel_mask #(
    .COORD_BITS(COORD_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out)
  );

  always #5 clk = ~clk;

  function automatic pixel_t vignette(located_pixel_t p);
    longint cx, cy, m, dx, dy, d2, num;
    int     gain;
    pixel_t o;
    cx = longint'(img_w / 2);
    cy = longint'(img_h / 2);
    m  = cx * cx + cy * cy;
    dx = longint'(p.x) - cx;
    dy = longint'(p.y) - cy;
    d2 = dx * dx + dy * dy;
    if (m == 0) begin
      gain = GAIN_MAX;
    end else begin
      num = longint'(GAIN_MAX) * m - longint'(GAIN_SLOPE) * d2;
      gain = (num <= 0) ? 0 : int'(num / m);
    end
    o.red   = CH_W'(int'(p.rgb.red) * gain / GAIN_MAX);
    o.green = CH_W'(int'(p.rgb.green) * gain / GAIN_MAX);
    o.blue  = CH_W'(int'(p.rgb.blue) * gain / GAIN_MAX);
    return o;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(int dim);
    if (dim < 2 || $urandom_range(3) == 0) begin
      return COORD_W'($urandom_range(4095));
    end
    return COORD_W'($urandom_range((dim > 4096 ? 4096 : dim) - 1));
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_pixel(int x, int y, int r, int g, int b);
    located_pixel_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.rgb.red = CH_W'(r);
    p.rgb.green = CH_W'(g);
    p.rgb.blue = CH_W'(b);
    pending_pixels.push_back(p);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= DIM_W'(value);
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = value;
    end else begin
      img_h = value;
    end
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain;
    while (pending_pixels.size() != 0 || masked_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // driver
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!(pix_valid && !pix_taken)) begin
      if (!rst && pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_valid <= 1'b1;
        pos_x <= pending_pixels[0].x;
        pos_y <= pending_pixels[0].y;
        red_in <= pending_pixels[0].rgb.red;
        green_in <= pending_pixels[0].rgb.green;
        blue_in <= pending_pixels[0].rgb.blue;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pix_taken = 1'b0;
    if (!rst && pix_valid && !pix_stall) begin
      pix_taken = 1'b1;
      taken_pixel = pending_pixels.pop_front();
      masked_due.push_back(vignette(taken_pixel));
      pixels_in++;
    end
    if (!rst && res_valid && !res_stall) begin
      pixels_out++;
      if (masked_due.size() == 0) begin
        report($sformatf("unexpected transfer %0d/%0d/%0d", red_out, green_out, blue_out));
      end else begin
        due_pixel = masked_due.pop_front();
        if (red_out !== due_pixel.red) begin
          report($sformatf("red_out got %0d want %0d", red_out, due_pixel.red));
        end
        if (green_out !== due_pixel.green) begin
          report($sformatf("green_out got %0d want %0d", green_out, due_pixel.green));
        end
        if (blue_out !== due_pixel.blue) begin
          report($sformatf("blue_out got %0d want %0d", blue_out, due_pixel.blue));
        end
      end
    end
    if (pix_taken || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", IDLE_LIMIT,
               masked_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  int size_w[NUM_SIZES] = '{2, 4096, 0, 8191, 640, 3, 1, 0, 0};
  int size_h[NUM_SIZES] = '{2, 4096, 0, 1, 480, 4096, 1, 0, 0};

  initial begin
    size_w[7] = $urandom_range(2, 4096);
    size_h[7] = $urandom_range(2, 4096);
    size_w[8] = $urandom_range(8191);
    size_h[8] = $urandom_range(8191);
    send_idle_pct = 28;
    recv_idle_pct = 56;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset size 256x256
    add_pixel(128, 128, 255, 255, 255);
    add_pixel(128, 128, 0, 0, 0);
    add_pixel(128, 128, 1, 254, 128);
    add_pixel(0, 0, 255, 255, 255);
    add_pixel(255, 255, 255, 255, 255);
    add_pixel(255, 0, 255, 255, 255);
    add_pixel(0, 128, 200, 100, 50);
    add_pixel(128, 0, 50, 100, 200);
    add_pixel(256, 256, 255, 255, 255);
    add_pixel(4095, 4095, 255, 255, 255);
    add_pixel(4095, 0, 255, 255, 255);
    add_pixel(0, 4095, 255, 255, 255);
    add_pixel(129, 127, 255, 1, 0);
    add_pixel(200, 50, 255, 0, 170);
    sizes_run = 1;

    for (int s = 0; s < NUM_SIZES; s++) begin
      drain();
      if (s == NUM_SIZES / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 28;
      end else if (s == 2 * NUM_SIZES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_IMAGE_WIDTH, size_w[s]);
      write_reg(REG_IMAGE_HEIGHT, size_h[s]);
      // radius register settles after a size write
      repeat (4) @(negedge clk);
      sizes_run++;
      add_pixel(size_w[s] / 2, size_h[s] / 2, 255, 255, 255);
      add_pixel(0, 0, 255, 255, 255);
      for (int i = 0; i < RAND_PER_SIZE; i++) begin
        add_pixel(int'(rand_coord(size_w[s])), int'(rand_coord(size_h[s])),
                  int'($urandom_range(255)), int'($urandom_range(255)),
                  int'($urandom_range(255)));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d pixels and checked %0d masked transfers over %0d image sizes",
             pixels_in, pixels_out, sizes_run);
    $display("stall mixes 28/56, 56/28 and none; %0d mismatches", mismatches);
    if (mismatches == 0 && masked_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
